### rtl/core/nrmc_pkg.sv
// Shared types and constants for the NMEA RMC date/time extractor.
package nrmc_pkg;

    localparam int CHAR_W    = 8;
    localparam int PAIR_W    = 16;
    localparam int FIELD_LEN = 6;
    localparam int HDR_LEN   = 6;

    localparam logic [CHAR_W-1:0] COMMA_CH = 8'h2C;
    localparam logic [CHAR_W-1:0] ZERO_CH  = 8'h30;

    // "$GPRMC", first character at index 0
    localparam logic [CHAR_W-1:0] HDR_TEXT [HDR_LEN] = '{
        8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43
    };

    localparam logic [3:0] DATE_COMMA = 4'd9;

    // parse phase codes
    localparam logic [2:0] PH_WAIT_LINE = 3'd0;
    localparam logic [2:0] PH_WAIT_TIME = 3'd1;
    localparam logic [2:0] PH_GRAB_TIME = 3'd2;
    localparam logic [2:0] PH_WAIT_DATE = 3'd3;
    localparam logic [2:0] PH_GRAB_DATE = 3'd4;

    // result kinds
    localparam logic EV_DATETIME   = 1'b0;
    localparam logic EV_INVALIDATE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [PAIR_W-1:0] year;
        logic [PAIR_W-1:0] month;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
    } nrmc_event_t;

endpackage

### rtl/core/nmea_rmc_datetime_extractor.sv
// Top level of the NMEA RMC date/time extractor with registered result channel.
// The result is registered: it appears on m_* in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the result slot is empty or drains in the same
//   cycle; a result held by a low m_ready drops s_ready until it is taken.
// Reset (aresetn low, synchronous): window cleared, parser waits for a header,
//   captured characters set to ASCII '0', result register emptied.
module nmea_rmc_datetime_extractor import nrmc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // byte input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_in,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_event_kind,
    output logic [PAIR_W-1:0] m_year_chars,
    output logic [PAIR_W-1:0] m_month_chars,
    output logic [PAIR_W-1:0] m_day_chars,
    output logic [PAIR_W-1:0] m_hour_chars,
    output logic [PAIR_W-1:0] m_minute_chars,
    output logic [PAIR_W-1:0] m_second_chars
);

    logic        s_xfer;
    nrmc_event_t parse_event;
    nrmc_event_t result_reg;
    logic        m_valid_reg, m_valid_next;

    // a new byte can go in whenever the result slot is free or draining now
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    nrmc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (s_xfer),
        .char_in    (s_char_in),
        .event_out  (parse_event)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = parse_event.valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload only loads when the parser produces a transaction
    always_ff @(posedge aclk) begin
        if (s_xfer && parse_event.valid) begin
            result_reg <= parse_event;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = result_reg.kind;
    assign m_year_chars   = result_reg.year;
    assign m_month_chars  = result_reg.month;
    assign m_day_chars    = result_reg.day;
    assign m_hour_chars   = result_reg.hour;
    assign m_minute_chars = result_reg.minute;
    assign m_second_chars = result_reg.second;

    // an invalidate transaction carries all-zero character fields
    a_inval_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == EV_INVALIDATE)
        |-> (m_year_chars == '0 && m_month_chars == '0 && m_day_chars == '0 &&
             m_hour_chars == '0 && m_minute_chars == '0 && m_second_chars == '0))
        else $error("invalidate result with nonzero fields");

    // an accepted byte that yields no result leaves the slot empty
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !parse_event.valid) |=> !m_valid)
        else $error("result appeared without a cause");

    // a result waiting on a stalled consumer is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_xfer)
        else $error("input accepted over a stalled result");

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### rtl/core/nrmc_parser.sv
// Per-byte sentence parser: header window, phase tracking and field capture.
module nrmc_parser import nrmc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              char_valid,
    input  logic [CHAR_W-1:0] char_in,
    output nrmc_event_t       event_out
);

    // only the previous five bytes are kept; the sixth is the incoming byte
    logic [CHAR_W-1:0] win_reg  [HDR_LEN-1];
    logic [CHAR_W-1:0] win_next [HDR_LEN-1];
    logic [2:0]        phase_reg, phase_next;
    logic [3:0]        comma_cnt_reg, comma_cnt_next;
    logic [2:0]        char_pos_reg, char_pos_next;
    // date bytes ddmmy (last y comes straight from the input), time bytes hhmmss
    logic [CHAR_W-1:0] date_reg  [FIELD_LEN-1];
    logic [CHAR_W-1:0] date_next [FIELD_LEN-1];
    logic [CHAR_W-1:0] time_reg  [FIELD_LEN];
    logic [CHAR_W-1:0] time_next [FIELD_LEN];

    logic hdr_match;
    logic is_comma;
    logic last_pos;

    assign is_comma = (char_in == COMMA_CH);
    assign last_pos = (char_pos_reg == 3'(FIELD_LEN - 1));

    always_comb begin
        hdr_match = (char_in == HDR_TEXT[HDR_LEN-1]);
        for (int i = 0; i < HDR_LEN - 1; i++) begin
            hdr_match = hdr_match && (win_reg[i] == HDR_TEXT[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_LEN - 2; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[HDR_LEN-2] = char_in;

        phase_next     = phase_reg;
        comma_cnt_next = comma_cnt_reg;
        char_pos_next  = char_pos_reg;
        date_next      = date_reg;
        time_next      = time_reg;

        event_out        = '0;
        event_out.kind   = EV_INVALIDATE;

        if (hdr_match) begin
            phase_next     = PH_WAIT_TIME;
            comma_cnt_next = '0;
            for (int i = 0; i < FIELD_LEN - 1; i++) date_next[i] = ZERO_CH;
            for (int i = 0; i < FIELD_LEN; i++)     time_next[i] = ZERO_CH;
        end else begin
            case (phase_reg)
                PH_WAIT_LINE: begin
                end
                PH_WAIT_TIME: begin
                    if (!is_comma) begin
                        event_out.valid = 1'b1;
                        phase_next      = PH_WAIT_LINE;
                    end else begin
                        comma_cnt_next = comma_cnt_reg + 4'd1;
                        phase_next     = PH_GRAB_TIME;
                        char_pos_next  = '0;
                    end
                end
                PH_GRAB_TIME: begin
                    if (is_comma) begin
                        event_out.valid = 1'b1;
                        phase_next      = PH_WAIT_LINE;
                    end else begin
                        for (int i = 0; i < FIELD_LEN; i++) begin
                            if (char_pos_reg == 3'(i)) time_next[i] = char_in;
                        end
                        char_pos_next = char_pos_reg + 3'd1;
                        if (last_pos) phase_next = PH_WAIT_DATE;
                    end
                end
                PH_WAIT_DATE: begin
                    if (is_comma) comma_cnt_next = comma_cnt_reg + 4'd1;
                    if (comma_cnt_next == DATE_COMMA) begin
                        phase_next    = PH_GRAB_DATE;
                        char_pos_next = '0;
                    end
                end
                PH_GRAB_DATE: begin
                    if (is_comma) begin
                        event_out.valid = 1'b1;
                        phase_next      = PH_WAIT_LINE;
                    end else begin
                        for (int i = 0; i < FIELD_LEN - 1; i++) begin
                            if (char_pos_reg == 3'(i)) date_next[i] = char_in;
                        end
                        char_pos_next = char_pos_reg + 3'd1;
                        if (last_pos) begin
                            // reorder ddmmyy to yy mm dd
                            event_out.valid  = 1'b1;
                            event_out.kind   = EV_DATETIME;
                            event_out.year   = {date_reg[4], char_in};
                            event_out.month  = {date_reg[2], date_reg[3]};
                            event_out.day    = {date_reg[0], date_reg[1]};
                            event_out.hour   = {time_reg[0], time_reg[1]};
                            event_out.minute = {time_reg[2], time_reg[3]};
                            event_out.second = {time_reg[4], time_reg[5]};
                            phase_next       = PH_WAIT_LINE;
                        end
                    end
                end
                default: begin
                    phase_next = PH_WAIT_LINE;
                end
            endcase
        end

        if (!char_valid) begin
            event_out.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_LINE;
            comma_cnt_reg <= '0;
            char_pos_reg  <= '0;
            for (int i = 0; i < HDR_LEN - 1; i++)   win_reg[i]  <= '0;
            for (int i = 0; i < FIELD_LEN - 1; i++) date_reg[i] <= ZERO_CH;
            for (int i = 0; i < FIELD_LEN; i++)     time_reg[i] <= ZERO_CH;
        end else if (char_valid) begin
            phase_reg     <= phase_next;
            comma_cnt_reg <= comma_cnt_next;
            char_pos_reg  <= char_pos_next;
            win_reg       <= win_next;
            date_reg      <= date_next;
            time_reg      <= time_next;
        end
    end

    // phase stays within the defined codes
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_GRAB_DATE)
        else $error("parse phase out of range");

    // the comma count never runs past the date comma
    a_comma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        comma_cnt_reg <= DATE_COMMA)
        else $error("comma count past date field");

    // field position stays inside a field while capturing
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_GRAB_TIME || phase_reg == PH_GRAB_DATE)
        |-> char_pos_reg < 3'(FIELD_LEN))
        else $error("capture position out of field");

endmodule
